[rtl/mblm_pkg.sv]
// Shared types and constants for the multi-buffer reader lock manager.
`timescale 1ns / 1ps

package mblm_pkg;

  // Ring and reader dimensions.
  localparam int NUM_BUFFERS = 8;
  localparam int NUM_READERS = 4;
  localparam int IDX_W       = 4;
  localparam int BUF_W       = 3;
  localparam int CNT_W       = 3;
  localparam int RID_W       = 2;

  // Index value that encodes "no buffer".
  localparam logic [IDX_W-1:0] NONE_IDX  = 4'hF;
  localparam logic [CNT_W-1:0] COUNT_MAX = 3'd7;

  // Field widths.
  localparam int ACTIVE_W = 4;
  localparam int SIZE_W   = 31;
  localparam int OFFS_W   = 16;
  localparam int ADDR_W   = 34;
  localparam int STAMP_W  = 63;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BUFFERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET    = 2'd2;

  // Request codes.
  typedef enum logic [1:0] {
    FUNC_WR_ACQ = 2'd0,
    FUNC_WR_REL = 2'd1,
    FUNC_RD_ACQ = 2'd2,
    FUNC_RD_REL = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [RID_W-1:0]   reader_id;
    logic               only_new;
    logic [STAMP_W-1:0] now_ms;
  } mblm_req_t;

  typedef struct packed {
    logic               ok;
    logic [BUF_W-1:0]   buffer_index;
    logic [ADDR_W-1:0]  buffer_address;
    logic [STAMP_W-1:0] stamp_ms;
  } mblm_rsp_t;

endpackage

[rtl/multi_buffer_reader_lock_manager.sv]
// Lock manager for a ring of frame buffers shared by one writer and several readers.
`timescale 1ns / 1ps
// Sequence: a writer release, a reader release or a refused reader acquire goes EXEC, DONE;
//   a granted reader acquire goes EXEC, ADDR, DONE. A writer acquire goes EXEC, then SCAN
//   until it finds a free buffer (then ADDR, DONE) or has tried the whole ring (then DONE).
// One item at a time: busy stays high through the strobe cycle; the receiver cannot stall.
// Async reset: nothing held or published, counts zero, active_buffers 8, size and offset 0.

module multi_buffer_reader_lock_manager
  import mblm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  mblm_req_t            req_i,
  output logic                 rsp_valid_o,
  output mblm_rsp_t            rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Sequencer states. EXEC decodes the request, SCAN walks the ring one buffer a
  // cycle, ADDR runs the shift-add address unit one index bit a cycle, DONE shows
  // the result.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_ADDR = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [ACTIVE_W-1:0] active_q;
  logic [SIZE_W-1:0]   size_q;
  logic [OFFS_W-1:0]   offs_q;

  // Lock state.
  logic [IDX_W-1:0]   held_q, held_d;
  logic [IDX_W-1:0]   latest_q, latest_d;
  logic [IDX_W-1:0]   writing_q, writing_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [CNT_W-1:0]   counts_q [NUM_BUFFERS];
  logic [CNT_W-1:0]   counts_d [NUM_BUFFERS];
  logic [IDX_W-1:0]   holds_q [NUM_READERS];
  logic [IDX_W-1:0]   holds_d [NUM_READERS];

  // Item and working registers.
  mblm_req_t         req_q;
  mblm_rsp_t         rsp_q, rsp_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  step_q, step_d;
  logic [IDX_W-1:0]  ring_q, ring_d;
  logic [1:0]        bit_q, bit_d;
  logic [ADDR_W-1:0] acc_q, acc_d;

  logic              accept;
  logic [IDX_W-1:0]  ring_size;
  logic [IDX_W-1:0]  scan_start;
  logic [IDX_W-1:0]  ptr_next;
  logic [IDX_W-1:0]  rd_hold;
  logic              rd_refuse;
  logic [ADDR_W-1:0] addend;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign rsp_valid_o = (state_q == ST_DONE);
  assign rsp_o       = rsp_q;

  // The ring never exceeds the number of physical buffers.
  assign ring_size  = (active_q > IDX_W'(NUM_BUFFERS)) ? IDX_W'(NUM_BUFFERS) : active_q;

  // The writer search starts just after the held buffer; when that lies past the
  // end of the ring, the first pass is empty and the scan begins at zero.
  assign scan_start = (held_q == NONE_IDX || (held_q + 1'b1) >= ring_size) ?
                      '0 : held_q + 1'b1;
  assign ptr_next   = (ptr_q + 1'b1 >= ring_q) ? '0 : ptr_q + 1'b1;

  assign rd_hold   = holds_q[req_q.reader_id];
  assign rd_refuse = (latest_q == NONE_IDX) || (latest_q == writing_q) ||
                     (req_q.only_new && latest_q == rd_hold);

  // The single adder of the address unit adds buffer_size shifted by the current
  // index bit.
  assign addend = ADDR_W'(size_q) << bit_q;

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    latest_d  = latest_q;
    writing_d = writing_q;
    stamp_d   = stamp_q;
    counts_d  = counts_q;
    holds_d   = holds_q;
    rsp_d     = rsp_q;
    ptr_d     = ptr_q;
    step_d    = step_q;
    ring_d    = ring_q;
    bit_d     = bit_q;
    acc_d     = acc_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        rsp_d = '0;
        state_d = ST_DONE;
        case (req_q.func)
          FUNC_WR_ACQ: begin
            ptr_d   = scan_start;
            step_d  = '0;
            ring_d  = ring_size;
            state_d = ST_SCAN;
          end
          FUNC_WR_REL: begin
            if (held_q != NONE_IDX) begin
              latest_d  = held_q;
              writing_d = NONE_IDX;
              stamp_d   = req_q.now_ms;
              held_d    = NONE_IDX;
              rsp_d.ok  = 1'b1;
            end
          end
          FUNC_RD_ACQ: begin
            if (int'(req_q.reader_id) < NUM_READERS && !rd_refuse) begin
              // Drop the old lock first, then count the new one; when both are the
              // same buffer the count comes out unchanged.
              for (int i = 0; i < NUM_BUFFERS; i++) begin
                if (rd_hold[IDX_W-1] == 1'b0 && rd_hold[BUF_W-1:0] == BUF_W'(i) &&
                    counts_d[i] != '0) begin
                  counts_d[i] = counts_d[i] - 1'b1;
                end
                if (latest_q[IDX_W-1] == 1'b0 && latest_q[BUF_W-1:0] == BUF_W'(i) &&
                    counts_d[i] != COUNT_MAX) begin
                  counts_d[i] = counts_d[i] + 1'b1;
                end
              end
              holds_d[req_q.reader_id] = latest_q;
              rsp_d.ok           = 1'b1;
              rsp_d.buffer_index = latest_q[BUF_W-1:0];
              rsp_d.stamp_ms     = stamp_q;
              acc_d              = ADDR_W'(offs_q);
              bit_d              = '0;
              state_d            = ST_ADDR;
            end
          end
          FUNC_RD_REL: begin
            if (int'(req_q.reader_id) < NUM_READERS && rd_hold != NONE_IDX) begin
              for (int i = 0; i < NUM_BUFFERS; i++) begin
                if (rd_hold[IDX_W-1] == 1'b0 && rd_hold[BUF_W-1:0] == BUF_W'(i) &&
                    counts_q[i] != '0) begin
                  counts_d[i] = counts_q[i] - 1'b1;
                end
              end
              holds_d[req_q.reader_id] = NONE_IDX;
              rsp_d.ok = 1'b1;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      ST_SCAN: begin
        if (step_q >= ring_q) begin
          // Every buffer in the ring is locked by a reader.
          state_d = ST_DONE;
        end else if (counts_q[ptr_q[BUF_W-1:0]] == '0) begin
          // Publish the buffer held so far, then hold the free one.
          if (held_q != NONE_IDX) begin
            latest_d = held_q;
            stamp_d  = req_q.now_ms;
          end
          held_d             = ptr_q;
          writing_d          = ptr_q;
          rsp_d.ok           = 1'b1;
          rsp_d.buffer_index = ptr_q[BUF_W-1:0];
          acc_d              = ADDR_W'(offs_q);
          bit_d              = '0;
          state_d            = ST_ADDR;
        end else begin
          ptr_d  = ptr_next;
          step_d = step_q + 1'b1;
        end
      end

      ST_ADDR: begin
        if (rsp_q.buffer_index[bit_q]) begin
          acc_d = acc_q + addend;
        end
        bit_d = bit_q + 1'b1;
        if (bit_q == 2'(BUF_W - 1)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        rsp_d.buffer_address = acc_q;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // The address is taken from the accumulator only after the last add.
    if (state_q == ST_ADDR && state_d == ST_DONE) begin
      rsp_d.buffer_address = acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      active_q  <= ACTIVE_W'(NUM_BUFFERS);
      size_q    <= '0;
      offs_q    <= '0;
      held_q    <= NONE_IDX;
      latest_q  <= NONE_IDX;
      writing_q <= NONE_IDX;
      stamp_q   <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        counts_q[i] <= '0;
      end
      for (int i = 0; i < NUM_READERS; i++) begin
        holds_q[i] <= NONE_IDX;
      end
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      latest_q  <= latest_d;
      writing_q <= writing_d;
      stamp_q   <= stamp_d;
      counts_q  <= counts_d;
      holds_q   <= holds_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE_BUFFERS: active_q <= cfg_wdata_i[ACTIVE_W-1:0];
          CFG_BUFFER_SIZE:    size_q   <= cfg_wdata_i[SIZE_W-1:0];
          CFG_BASE_OFFSET:    offs_q   <= cfg_wdata_i[OFFS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q  <= rsp_d;
    ptr_q  <= ptr_d;
    step_q <= step_d;
    ring_q <= ring_d;
    bit_q  <= bit_d;
    acc_q  <= acc_d;
  end

endmodule
